// File: hdl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/wmps_pkg.sv
// Shared types, widths and defaults for the weighted pattern match scorer.
package wmps_pkg;

    localparam int NODES_DEF        = 1024;
    localparam int ALPHABET_DEF     = 26;
    localparam int FENWICK_SIZE_DEF = 1026;

    localparam int CMD_W   = 3;
    localparam int NODE_W  = 10;
    localparam int SYM_W   = 5;
    localparam int POS_W   = 11;
    localparam int DELTA_W = 32;
    localparam int SCORE_W = 64;

    // Command codes carried by a request transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_TRANS = 3'd0,
        CMD_POS   = 3'd1,
        CMD_RANGE = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_SCAN  = 3'd4
    } cmd_t;

    // Operation after classification; invalid writes and unused codes are dropped.
    typedef enum logic [2:0] {
        OP_TRANS,
        OP_POS,
        OP_RANGE,
        OP_CLEAR,
        OP_SCAN
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [NODE_W-1:0]  node;
        logic [SYM_W-1:0]   symbol;
        logic [NODE_W-1:0]  next_node;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   range_low;
        logic [POS_W-1:0]   range_high;
        logic [DELTA_W-1:0] delta;
        logic               first;
        logic               last;
    } job_t;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } back_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN_TR,
        ST_SCAN_POS,
        ST_Q_RD,
        ST_Q_ACC,
        ST_EMIT
    } state_t;

endpackage

// File: hdl/wmps_if.sv
// Request and result channel interfaces of the pattern match scorer.
interface wmps_req_if import wmps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [NODE_W-1:0]  node;
    logic [SYM_W-1:0]   symbol;
    logic [NODE_W-1:0]  next_node;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   range_low;
    logic [POS_W-1:0]   range_high;
    logic [DELTA_W-1:0] delta;
    logic               first;
    logic               last;

    modport source (output valid, cmd, node, symbol, next_node, position, range_low,
                    range_high, delta, first, last, input ready);
    modport sink (input valid, cmd, node, symbol, next_node, position, range_low,
                  range_high, delta, first, last, output ready);
endinterface

interface wmps_res_if import wmps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] match_score;

    modport source (output valid, match_score, input ready);
    modport sink (input valid, match_score, output ready);
endinterface

// File: hdl/wmps_front.sv
// Front end: accepts request transactions, classifies them and queues jobs.
module wmps_front import wmps_pkg::*; #(
    parameter int NODES    = NODES_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    wmps_req_if.sink     request,
    input  back_status_t status,
    output job_t         job,
    output logic         job_valid,
    input  logic         job_ready
);

    job_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    job_t cls_job;
    logic cls_keep;
    logic push, pop;

    // Decode the command, drop unused codes and writes that would land outside the tables.
    always_comb
    begin
        cls_job            = '0;
        cls_job.node       = request.node;
        cls_job.symbol     = request.symbol;
        cls_job.next_node  = request.next_node;
        cls_job.position   = request.position;
        cls_job.range_low  = (request.range_low == '0) ? POS_W'(1) : request.range_low;
        cls_job.range_high = request.range_high;
        cls_job.delta      = request.delta;
        cls_job.first      = request.first;
        cls_job.last       = request.last;
        cls_keep           = 1'b0;
        case (cmd_t'(request.cmd))
            CMD_TRANS:
            begin
                cls_job.op = OP_TRANS;
                cls_keep   = (32'(request.node) < NODES) && (32'(request.next_node) < NODES)
                             && (32'(request.symbol) < ALPHABET);
            end
            CMD_POS:
            begin
                cls_job.op = OP_POS;
                cls_keep   = 32'(request.node) < NODES;
            end
            CMD_RANGE:
            begin
                cls_job.op = OP_RANGE;
                cls_keep   = 1'b1;
            end
            CMD_CLEAR:
            begin
                cls_job.op = OP_CLEAR;
                cls_keep   = 1'b1;
            end
            CMD_SCAN:
            begin
                cls_job.op = OP_SCAN;
                cls_keep   = 1'b1;
            end
            default:
            begin
                cls_job.op = OP_SCAN;
                cls_keep   = 1'b0;
            end
        endcase
    end

    // Two-entry queue between the front and the back end.
    assign request.ready = (count_reg != 2'd2) && !status.init_busy;
    assign push          = request.valid && request.ready && cls_keep;
    assign pop           = job_valid && job_ready;
    assign job_valid     = count_reg != 2'd0;
    assign job           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_job;
        end
    end

endmodule

// File: hdl/wmps_back.sv
// Back end: table memories, Fenwick weight store, scan sequencer and result register.
module wmps_back import wmps_pkg::*; #(
    parameter int NODES        = NODES_DEF,
    parameter int ALPHABET     = ALPHABET_DEF,
    parameter int FENWICK_SIZE = FENWICK_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  job_t         job,
    input  logic         job_valid,
    output logic         job_ready,
    output back_status_t status,
    wmps_res_if.source   result
);

    localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int TD  = NODES * ALPHABET;
    localparam int TAW = $clog2(TD);
    localparam int AW  = $clog2(FENWICK_SIZE + 1);
    localparam int IW  = (AW + 1 > POS_W + 1) ? AW + 1 : POS_W + 1;

    // Memories.
    logic [NW-1:0]      trans_mem [TD];
    logic [POS_W-1:0]   pos_mem [NODES];
    logic [SCORE_W-1:0] fen_mem [FENWICK_SIZE + 1];
    logic [NW-1:0]      trans_rdata_reg;
    logic [POS_W-1:0]   pos_rdata_reg;
    logic [SCORE_W-1:0] fen_rdata_reg;

    logic               trans_we, trans_re, pos_we, pos_re, fen_we, fen_re;
    logic [TAW-1:0]     trans_waddr, trans_raddr;
    logic [NW-1:0]      pos_waddr, pos_raddr;
    logic [AW-1:0]      fen_waddr, fen_raddr;
    logic [SCORE_W-1:0] fen_wdata;

    // Control and datapath registers.
    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [NW-1:0]      cur_node_reg, cur_node_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      hi_reg, hi_next;
    logic [SCORE_W-1:0] amount_reg, amount_next;
    logic [SCORE_W-1:0] sum_reg, sum_next;
    logic               phase_reg, phase_next;
    logic               last_reg, last_next;

    logic [IW-1:0]      idx_low;
    logic               idx_in_range;
    logic               clr_done;
    logic               out_free;
    logic               take;
    logic               sym_ok;
    logic [NW-1:0]      scan_node;
    logic [IW-1:0]      q_start;

    assign idx_low      = idx_reg & (~idx_reg + IW'(1));
    assign idx_in_range = (idx_reg != '0) && (idx_reg <= IW'(FENWICK_SIZE));
    assign clr_done     = clr_reg == AW'(FENWICK_SIZE);
    assign out_free     = !out_valid_reg || result.ready;
    assign job_ready    = state_reg == ST_IDLE;
    assign take         = job_valid && job_ready;
    assign sym_ok       = 32'(job.symbol) < ALPHABET;
    assign scan_node    = job.first ? '0 : cur_node_reg;
    assign q_start      = (32'(pos_rdata_reg) > FENWICK_SIZE) ? IW'(FENWICK_SIZE)
                                                              : IW'(pos_rdata_reg);

    assign status.init_busy   = state_reg == ST_INIT;
    assign status.idle        = state_reg == ST_IDLE;
    assign result.valid       = out_valid_reg;
    assign result.match_score = $signed(out_score_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT, ST_CLR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (job.op)
                        OP_RANGE: state_next = ST_ADD_RD;
                        OP_CLEAR: state_next = ST_CLR;
                        OP_SCAN:  state_next = sym_ok ? ST_SCAN_TR : ST_SCAN_POS;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                if (idx_in_range)
                begin
                    state_next = ST_ADD_WR;
                end
                else if (phase_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_WR:   state_next = ST_ADD_RD;
            ST_SCAN_TR:  state_next = ST_SCAN_POS;
            ST_SCAN_POS: state_next = ST_Q_RD;
            ST_Q_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    state_next = ST_Q_ACC;
                end
            end
            ST_Q_ACC:    state_next = ST_Q_RD;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Register updates of the datapath.
    always_comb
    begin
        clr_next       = clr_reg;
        cur_node_next  = cur_node_reg;
        score_next     = score_reg;
        idx_next       = idx_reg;
        hi_next        = hi_reg;
        amount_next    = amount_reg;
        sum_next       = sum_reg;
        phase_next     = phase_reg;
        last_next      = last_reg;
        out_score_next = out_score_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            ST_INIT, ST_CLR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (job.op)
                        OP_RANGE:
                        begin
                            idx_next    = IW'(job.range_low);
                            hi_next     = IW'(job.range_high) + IW'(1);
                            amount_next = SCORE_W'(job.delta);
                            phase_next  = 1'b0;
                        end
                        OP_CLEAR:
                        begin
                            clr_next = '0;
                        end
                        OP_SCAN:
                        begin
                            cur_node_next = scan_node;
                            score_next    = job.first ? '0 : score_reg;
                            last_next     = job.last;
                        end
                        default:
                        begin
                            last_next = last_reg;
                        end
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                if (!idx_in_range && !phase_reg)
                begin
                    phase_next  = 1'b1;
                    idx_next    = hi_reg;
                    amount_next = '0 - amount_reg;
                end
            end
            ST_ADD_WR:
            begin
                idx_next = idx_reg + idx_low;
            end
            ST_SCAN_TR:
            begin
                cur_node_next = trans_rdata_reg;
            end
            ST_SCAN_POS:
            begin
                idx_next = q_start;
                sum_next = '0;
            end
            ST_Q_RD:
            begin
                if (idx_reg == '0)
                begin
                    score_next = score_reg + sum_reg;
                end
            end
            ST_Q_ACC:
            begin
                sum_next = sum_reg + fen_rdata_reg;
                idx_next = idx_reg - idx_low;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_score_next = score_reg;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // Memory port controls.
    always_comb
    begin
        trans_we    = 1'b0;
        trans_re    = 1'b0;
        trans_waddr = TAW'(32'(job.node) * ALPHABET + 32'(job.symbol));
        trans_raddr = TAW'(32'(scan_node) * ALPHABET + 32'(job.symbol));
        pos_we      = 1'b0;
        pos_re      = 1'b0;
        pos_waddr   = NW'(job.node);
        pos_raddr   = scan_node;
        fen_we      = 1'b0;
        fen_re      = 1'b0;
        fen_waddr   = idx_reg[AW-1:0];
        fen_raddr   = idx_reg[AW-1:0];
        fen_wdata   = fen_rdata_reg + amount_reg;
        case (state_reg)
            ST_INIT, ST_CLR:
            begin
                fen_we    = 1'b1;
                fen_waddr = clr_reg;
                fen_wdata = '0;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    trans_we = job.op == OP_TRANS;
                    pos_we   = job.op == OP_POS;
                    trans_re = (job.op == OP_SCAN) && sym_ok;
                    pos_re   = (job.op == OP_SCAN) && !sym_ok;
                end
            end
            ST_ADD_RD:
            begin
                fen_re = idx_in_range;
            end
            ST_ADD_WR:
            begin
                fen_we = 1'b1;
            end
            ST_SCAN_TR:
            begin
                pos_re    = 1'b1;
                pos_raddr = trans_rdata_reg;
            end
            ST_Q_RD:
            begin
                fen_re = idx_reg != '0;
            end
            default:
            begin
                fen_re = 1'b0;
            end
        endcase
    end

    // Memory arrays with registered read data.
    always_ff @(posedge clk)
    begin
        if (trans_we)
        begin
            trans_mem[trans_waddr] <= job.next_node[NW-1:0];
        end
        if (trans_re)
        begin
            trans_rdata_reg <= trans_mem[trans_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= job.position;
        end
        if (pos_re)
        begin
            pos_rdata_reg <= pos_mem[pos_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen_we)
        begin
            fen_mem[fen_waddr] <= fen_wdata;
        end
        if (fen_re)
        begin
            fen_rdata_reg <= fen_mem[fen_raddr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cur_node_reg  <= '0;
            score_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            cur_node_reg  <= cur_node_next;
            score_reg     <= score_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hi_reg        <= hi_next;
        amount_reg    <= amount_next;
        sum_reg       <= sum_next;
        phase_reg     <= phase_next;
        last_reg      <= last_next;
        out_score_reg <= out_score_next;
    end

endmodule

// File: hdl/weighted_multi_pattern_match_score_core.sv
// Top level of the weighted multi-pattern match scorer.
//
//  Channel   Direction  Carries
//  request   in         cmd, node, symbol, next_node, position, range, delta, first, last
//  result    out        match_score, one per scan transaction with last set
//
// A scan holds the back end through a transition lookup, a position read and a Fenwick walk
// with one store read per set bit of the node's saturated position; a symbol outside the
// alphabet skips the transition lookup, and a scan with last set adds an emit step. The
// Fenwick walk over the single store read port sets the length of a scan. A range add reads
// and writes each entry it visits, and a clear writes every Fenwick entry. After reset a
// clearing pass runs while request.ready stays low. A two-entry job queue and the result
// register let request keep flowing while a result waits.
`include "assert_macros.svh"
module weighted_multi_pattern_match_score_core import wmps_pkg::*; #(
    parameter int NODES        = NODES_DEF,
    parameter int ALPHABET     = ALPHABET_DEF,
    parameter int FENWICK_SIZE = FENWICK_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    wmps_req_if.sink   request,
    wmps_res_if.source result
);

    job_t         job;
    logic         job_valid;
    logic         job_ready;
    back_status_t status;

    wmps_front #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .status    (status),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    wmps_back #(
        .NODES        (NODES),
        .ALPHABET     (ALPHABET),
        .FENWICK_SIZE (FENWICK_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .status    (status),
        .result    (result)
    );

    // No request transaction is taken during the clearing pass after reset.
    `ASSERT_IMPLIES(a_no_req_in_init, status.init_busy, !request.ready, "request during init")
    // A job leaves the queue only while the back end is idle.
    `ASSERT_IMPLIES(a_job_when_idle, job_valid && job_ready, status.idle, "job while busy")
    // The back end never reports idle and clearing at once.
    `ASSERT_ALWAYS(a_status_excl, !(status.init_busy && status.idle), "bad status")

endmodule
